>>> rtl/core/dual_uart_ring_buffers_core_defines.svh
// assertion helpers for the serial ring buffer core
`ifndef DUAL_UART_RING_BUFFERS_CORE_DEFINES_SVH
`define DUAL_UART_RING_BUFFERS_CORE_DEFINES_SVH

// same-cycle implication
`define DURB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("durb assertion failed");

// next-cycle implication
`define DURB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("durb assertion failed");

`endif

>>> rtl/core/durb_pkg.sv
`timescale 1ns / 1ps

package durb_pkg;

  localparam int unsigned RING_DEPTH_DEF   = 256;
  localparam int unsigned NUM_CHANNELS_DEF = 2;
  localparam logic [7:0]  COUNT_MAX        = 8'd255;

  typedef enum logic [2:0] {
    KIND_RX_BYTE  = 3'd0,
    KIND_READ     = 3'd1,
    KIND_WRITE    = 3'd2,
    KIND_TX_READY = 3'd3,
    KIND_FLUSH    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RX_FULL  = 3'd1,
    ST_RD_EMPTY = 3'd2,
    ST_TX_FULL  = 3'd3,
    ST_NO_SEND  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_e;

  typedef struct packed {
    logic [2:0] kind;
    logic       channel;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte;
    logic       read_valid;
    logic [7:0] send_byte;
    logic       send_valid;
    logic [7:0] rx_count;
    logic [7:0] rx_front;
    logic       rx_nonempty;
  } out_item_t;

  // outcome of one item, handed from pointer control to the result stage
  typedef struct packed {
    status_e    status;
    logic       ch_ok;
    logic       rx_pop;
    logic       tx_pop;
    logic       front_fwd;
    logic [7:0] count;
  } step_t;

endpackage

>>> rtl/core/durb_ram.sv
`timescale 1ns / 1ps

module durb_ram import durb_pkg::*; #(
  parameter int unsigned NCH   = NUM_CHANNELS_DEF,
  parameter int unsigned DEPTH = RING_DEPTH_DEF,
  parameter int unsigned CW    = 1,
  parameter int unsigned PW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [CW-1:0] wch_i,
  input  logic [PW-1:0] wptr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [CW-1:0] rch_i,
  input  logic [PW-1:0] rptr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [NCH][DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wch_i][wptr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[rch_i][rptr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/durb_ctrl.sv
`timescale 1ns / 1ps

module durb_ctrl import durb_pkg::*; #(
  parameter int unsigned RING_DEPTH   = RING_DEPTH_DEF,
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  in_item_t      item_i,
  output step_t         step_o,
  output logic [CW-1:0] ch_o,
  output logic          rx_we_o,
  output logic [PW-1:0] rx_wptr_o,
  output logic [PW-1:0] rx_pop_ptr_o,
  output logic [PW-1:0] rx_front_ptr_o,
  output logic          tx_we_o,
  output logic [PW-1:0] tx_wptr_o,
  output logic [PW-1:0] tx_pop_ptr_o
);

  localparam logic [PW-1:0] LAST_V  = PW'(RING_DEPTH - 1);
  localparam logic [PW:0]   DEPTH_V = (PW + 1)'(RING_DEPTH);

  logic [PW-1:0] rx_wr_q [NUM_CHANNELS];
  logic [PW-1:0] rx_rd_q [NUM_CHANNELS];
  logic [PW-1:0] tx_wr_q [NUM_CHANNELS];
  logic [PW-1:0] tx_rd_q [NUM_CHANNELS];

  logic [CW-1:0] ch;
  logic          ch_ok;
  logic [PW-1:0] rx_wr, rx_rd, tx_wr, tx_rd;
  logic [PW-1:0] rx_wr_inc, rx_rd_inc, tx_wr_inc, tx_rd_inc;
  logic [PW-1:0] rx_wr_d, rx_rd_d, tx_wr_d, tx_rd_d;
  logic [PW:0]   cnt_raw;
  logic          rx_we, tx_we;
  step_t         step;

  assign ch    = CW'(item_i.channel);
  assign ch_ok = (int'(item_i.channel) < NUM_CHANNELS);

  assign rx_wr = rx_wr_q[ch];
  assign rx_rd = rx_rd_q[ch];
  assign tx_wr = tx_wr_q[ch];
  assign tx_rd = tx_rd_q[ch];

  assign rx_wr_inc = (rx_wr == LAST_V) ? '0 : rx_wr + PW'(1);
  assign rx_rd_inc = (rx_rd == LAST_V) ? '0 : rx_rd + PW'(1);
  assign tx_wr_inc = (tx_wr == LAST_V) ? '0 : tx_wr + PW'(1);
  assign tx_rd_inc = (tx_rd == LAST_V) ? '0 : tx_rd + PW'(1);

  always_comb begin
    rx_wr_d = rx_wr;
    rx_rd_d = rx_rd;
    tx_wr_d = tx_wr;
    tx_rd_d = tx_rd;
    rx_we   = 1'b0;
    tx_we   = 1'b0;
    step    = '0;
    step.status = ST_OK;
    step.ch_ok  = ch_ok;
    unique case (item_i.kind)
      KIND_RX_BYTE: begin
        if (rx_wr_inc != rx_rd) begin
          rx_we          = 1'b1;
          rx_wr_d        = rx_wr_inc;
          step.front_fwd = (rx_wr == rx_rd);
        end else begin
          step.status = ST_RX_FULL;
        end
      end
      KIND_READ: begin
        if (rx_wr == rx_rd) begin
          step.status = ST_RD_EMPTY;
        end else begin
          step.rx_pop = 1'b1;
          rx_rd_d     = rx_rd_inc;
        end
      end
      KIND_WRITE: begin
        if (tx_wr_inc != tx_rd) begin
          tx_we   = 1'b1;
          tx_wr_d = tx_wr_inc;
        end else begin
          step.status = ST_TX_FULL;
        end
      end
      KIND_TX_READY: begin
        if (tx_wr == tx_rd) begin
          step.status = ST_NO_SEND;
        end else begin
          step.tx_pop = 1'b1;
          tx_rd_d     = tx_rd_inc;
        end
      end
      KIND_FLUSH: begin
        rx_wr_d = '0;
        rx_rd_d = '0;
      end
      default: begin
      end
    endcase
    if (rx_wr_d >= rx_rd_d) begin
      cnt_raw = {1'b0, rx_wr_d} - {1'b0, rx_rd_d};
    end else begin
      cnt_raw = {1'b0, rx_wr_d} + DEPTH_V - {1'b0, rx_rd_d};
    end
    step.count = (int'(cnt_raw) > 255) ? COUNT_MAX : 8'(cnt_raw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rx_wr_q[i] <= '0;
        rx_rd_q[i] <= '0;
        tx_wr_q[i] <= '0;
        tx_rd_q[i] <= '0;
      end
    end else if (acc_i && ch_ok) begin
      rx_wr_q[ch] <= rx_wr_d;
      rx_rd_q[ch] <= rx_rd_d;
      tx_wr_q[ch] <= tx_wr_d;
      tx_rd_q[ch] <= tx_rd_d;
    end
  end

  assign step_o         = step;
  assign ch_o           = ch;
  assign rx_we_o        = acc_i && ch_ok && rx_we;
  assign rx_wptr_o      = rx_wr;
  assign rx_pop_ptr_o   = rx_rd;
  assign rx_front_ptr_o = rx_rd_d;
  assign tx_we_o        = acc_i && ch_ok && tx_we;
  assign tx_wptr_o      = tx_wr;
  assign tx_pop_ptr_o   = tx_rd;

endmodule

>>> rtl/core/dual_uart_ring_buffers_core.sv
// Serial ring buffer core: per channel one receive ring and one transmit ring.
// Input channel in_valid_i / in_ready_o / in_item_i carries kind, channel and
// data; output channel out_valid_o / out_ready_i / out_item_o carries exactly
// one result item per accepted input item, in order.
// An item is taken in the cycle it is accepted: pointers update and the byte
// stores are written and read at that edge. The result is then formed from the
// registered memory read data and moved into the output register once that
// register is free, which raises out_valid_o. One item is in work at a time: a
// new item is accepted only after the last result has moved into the output
// register, as the byte stores have a registered read.
// The output register stands between the two sides: while a result waits for
// out_ready_i, a new item is still accepted and worked on; its result then
// holds in the result stage and in_ready_o stays low until the output frees.
// Reset clears all ring pointers (all rings empty) and the valid flags; no
// clearing pass runs, the block takes items right after reset.
`timescale 1ns / 1ps
`include "dual_uart_ring_buffers_core_defines.svh"

module dual_uart_ring_buffers_core import durb_pkg::*; #(
  parameter int unsigned RING_DEPTH   = RING_DEPTH_DEF,
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  state_e        state_q, state_d;
  step_t         step, step_q;
  logic [7:0]    data_q;
  logic          acc;
  logic [CW-1:0] ch;
  logic          rx_we, tx_we;
  logic [PW-1:0] rx_wptr, rx_pop_ptr, rx_front_ptr, tx_wptr, tx_pop_ptr;
  logic [7:0]    rx_pop_data, rx_front_data, tx_pop_data;
  logic          load;
  out_item_t     res;
  out_item_t     out_q;
  logic          out_valid_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  durb_ctrl #(
    .RING_DEPTH  (RING_DEPTH),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .item_i        (in_item_i),
    .step_o        (step),
    .ch_o          (ch),
    .rx_we_o       (rx_we),
    .rx_wptr_o     (rx_wptr),
    .rx_pop_ptr_o  (rx_pop_ptr),
    .rx_front_ptr_o(rx_front_ptr),
    .tx_we_o       (tx_we),
    .tx_wptr_o     (tx_wptr),
    .tx_pop_ptr_o  (tx_pop_ptr)
  );

  // receive store kept twice for a pop port and a peek port
  durb_ram #(
    .NCH(NUM_CHANNELS), .DEPTH(RING_DEPTH), .CW(CW), .PW(PW)
  ) u_rx_pop_ram (
    .clk_i  (clk_i),
    .we_i   (rx_we),
    .wch_i  (ch),
    .wptr_i (rx_wptr),
    .wdata_i(in_item_i.data),
    .re_i   (acc),
    .rch_i  (ch),
    .rptr_i (rx_pop_ptr),
    .rdata_o(rx_pop_data)
  );

  durb_ram #(
    .NCH(NUM_CHANNELS), .DEPTH(RING_DEPTH), .CW(CW), .PW(PW)
  ) u_rx_peek_ram (
    .clk_i  (clk_i),
    .we_i   (rx_we),
    .wch_i  (ch),
    .wptr_i (rx_wptr),
    .wdata_i(in_item_i.data),
    .re_i   (acc),
    .rch_i  (ch),
    .rptr_i (rx_front_ptr),
    .rdata_o(rx_front_data)
  );

  durb_ram #(
    .NCH(NUM_CHANNELS), .DEPTH(RING_DEPTH), .CW(CW), .PW(PW)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (tx_we),
    .wch_i  (ch),
    .wptr_i (tx_wptr),
    .wdata_i(in_item_i.data),
    .re_i   (acc),
    .rch_i  (ch),
    .rptr_i (tx_pop_ptr),
    .rdata_o(tx_pop_data)
  );

  always_ff @(posedge clk_i) begin
    if (acc) begin
      step_q <= step;
      data_q <= in_item_i.data;
    end
  end

  assign load = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res = '0;
    if (step_q.ch_ok) begin
      res.status      = step_q.status;
      res.read_valid  = step_q.rx_pop;
      res.read_byte   = step_q.rx_pop ? rx_pop_data : 8'd0;
      res.send_valid  = step_q.tx_pop;
      res.send_byte   = step_q.tx_pop ? tx_pop_data : 8'd0;
      res.rx_count    = step_q.count;
      res.rx_nonempty = (step_q.count != 8'd0);
      if (res.rx_nonempty) begin
        // a byte written into an empty ring is its own front
        res.rx_front = step_q.front_fwd ? data_q : rx_front_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `DURB_ASSERT_NEXT(a_accept_goes_resp, clk_i, rst_ni, acc,
                    (state_q == S_RESP) && !in_ready_o)
  `DURB_ASSERT_NOW(a_single_pop, clk_i, rst_ni, out_valid_o,
                   !(out_item_o.read_valid && out_item_o.send_valid))
  `DURB_ASSERT_NOW(a_fail_no_pop, clk_i, rst_ni,
                   out_valid_o && (out_item_o.status != ST_OK),
                   !out_item_o.read_valid && !out_item_o.send_valid)
  `DURB_ASSERT_NOW(a_nonempty_count, clk_i, rst_ni, out_valid_o,
                   out_item_o.rx_nonempty == (out_item_o.rx_count != 8'd0))

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import durb_pkg::*;

  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam int         HOLD_CYCLES    = 200;
  localparam int         BURST_ITEMS    = 40;
  localparam int         RANDOM_ITEMS   = 520;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  // ring model state
  logic [7:0] rx_mem [2][256];
  logic [7:0] tx_mem [2][256];
  logic [7:0] rx_wr [2];
  logic [7:0] rx_rd [2];
  logic [7:0] tx_wr [2];
  logic [7:0] tx_rd [2];

  out_item_t ring_outcomes [$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int        status_seen [5];
  logic      quiet_sides = 1'b0;
  logic      quiet_sender = 1'b0;
  logic      hold_off_req = 1'b0;

  dual_uart_ring_buffers_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic out_item_t predict_ring_step(in_item_t it);
    out_item_t  r;
    logic [7:0] nx;
    logic       c;
    r = '0;
    c = it.channel;
    case (it.kind)
      KIND_RX_BYTE: begin
        nx = rx_wr[c] + 8'd1;
        if (nx != rx_rd[c]) begin
          rx_mem[c][rx_wr[c]] = it.data;
          rx_wr[c] = nx;
        end else begin
          r.status = ST_RX_FULL;
        end
      end
      KIND_READ: begin
        if (rx_wr[c] == rx_rd[c]) begin
          r.status = ST_RD_EMPTY;
        end else begin
          r.read_byte = rx_mem[c][rx_rd[c]];
          r.read_valid = 1'b1;
          rx_rd[c] = rx_rd[c] + 8'd1;
        end
      end
      KIND_WRITE: begin
        nx = tx_wr[c] + 8'd1;
        if (nx != tx_rd[c]) begin
          tx_mem[c][tx_wr[c]] = it.data;
          tx_wr[c] = nx;
        end else begin
          r.status = ST_TX_FULL;
        end
      end
      KIND_TX_READY: begin
        if (tx_wr[c] == tx_rd[c]) begin
          r.status = ST_NO_SEND;
        end else begin
          r.send_byte = tx_mem[c][tx_rd[c]];
          r.send_valid = 1'b1;
          tx_rd[c] = tx_rd[c] + 8'd1;
        end
      end
      KIND_FLUSH: begin
        rx_wr[c] = 8'd0;
        rx_rd[c] = 8'd0;
      end
      default: begin
      end
    endcase
    // 256-deep ring: the 8-bit difference is the count
    r.rx_count = rx_wr[c] - rx_rd[c];
    if (r.rx_count != 8'd0) begin
      r.rx_nonempty = 1'b1;
      r.rx_front = rx_mem[c][rx_rd[c]];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("result %0d: %s", results_checked, msg);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic offer_item(input logic [2:0] kind, input logic ch, input logic [7:0] data);
    in_item_t  it;
    out_item_t pred;
    it.kind = kind;
    it.channel = ch;
    it.data = data;
    if (!quiet_sides && !quiet_sender && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = predict_ring_step(it);
    ring_outcomes.push_back(pred);
    status_seen[pred.status]++;
    items_sent++;
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ring_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_corner_items();
    offer_item(KIND_READ, 1'b0, 8'h00);
    offer_item(KIND_READ, 1'b1, 8'hff);
    offer_item(KIND_TX_READY, 1'b0, 8'h00);
    offer_item(KIND_FLUSH, 1'b1, 8'h00);
    offer_item(KIND_RX_BYTE, 1'b0, 8'h00);
    offer_item(KIND_RX_BYTE, 1'b0, 8'hff);
    offer_item(KIND_READ, 1'b0, 8'h00);
    offer_item(KIND_READ, 1'b0, 8'h00);
    offer_item(KIND_READ, 1'b0, 8'h00);
    offer_item(KIND_WRITE, 1'b1, 8'hff);
    offer_item(KIND_WRITE, 1'b0, 8'h00);
    offer_item(KIND_TX_READY, 1'b1, 8'h00);
    offer_item(KIND_TX_READY, 1'b0, 8'h00);
    // unused kinds leave the rings alone
    offer_item(KIND_RX_BYTE, 1'b1, 8'h80);
    offer_item(KIND_UNUSED_LO, 1'b1, 8'ha5);
    offer_item(3'(KIND_UNUSED_LO + 3'd1), 1'b0, 8'h5a);
    offer_item(KIND_UNUSED_HI, 1'b1, 8'hff);
    offer_item(KIND_RX_BYTE, 1'b1, 8'h7f);
    offer_item(KIND_FLUSH, 1'b1, 8'h00);
    offer_item(KIND_READ, 1'b1, 8'h00);
    offer_item(KIND_RX_BYTE, 1'b1, 8'h01);
    offer_item(KIND_READ, 1'b1, 8'h00);
  endtask

  task automatic test_rx_ring_full();
    // fill past full, drain part, refill across the wrap, then flush
    repeat (257) offer_item(KIND_RX_BYTE, 1'b0, 8'($urandom));
    repeat (100) offer_item(KIND_READ, 1'b0, 8'($urandom));
    repeat (101) offer_item(KIND_RX_BYTE, 1'b0, 8'($urandom));
    offer_item(KIND_FLUSH, 1'b0, 8'($urandom));
  endtask

  task automatic test_tx_ring_full();
    quiet_sides = 1'b1;
    repeat (257) offer_item(KIND_WRITE, 1'b1, 8'($urandom));
    quiet_sides = 1'b0;
    repeat (258) offer_item(KIND_TX_READY, 1'b1, 8'($urandom));
  endtask

  task automatic offer_random_item();
    int         r;
    logic [2:0] kind;
    r = $urandom_range(99);
    if (r < 33) kind = KIND_RX_BYTE;
    else if (r < 58) kind = KIND_READ;
    else if (r < 78) kind = KIND_WRITE;
    else if (r < 95) kind = KIND_TX_READY;
    else if (r < 98) kind = KIND_FLUSH;
    else kind = 3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
    offer_item(kind, 1'($urandom_range(1)), 8'($urandom));
  endtask

  task automatic test_random_traffic();
    repeat (RANDOM_ITEMS) offer_random_item();
  endtask

  task automatic test_backpressure();
    quiet_sender = 1'b1;
    hold_off_req = 1'b1;
    repeat (BURST_ITEMS) offer_random_item();
    quiet_sender = 1'b0;
    wait_all_results();
  endtask

  // result side: random stalls, a quiet stretch, and one long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (quiet_sides) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 15);
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ring_outcomes.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = ring_outcomes.pop_front();
        compare_field("status", 8'(out_item_o.status), 8'(want.status));
        compare_field("read_byte", out_item_o.read_byte, want.read_byte);
        compare_field("read_valid", 8'(out_item_o.read_valid), 8'(want.read_valid));
        compare_field("send_byte", out_item_o.send_byte, want.send_byte);
        compare_field("send_valid", 8'(out_item_o.send_valid), 8'(want.send_valid));
        compare_field("rx_count", out_item_o.rx_count, want.rx_count);
        compare_field("rx_front", out_item_o.rx_front, want.rx_front);
        compare_field("rx_nonempty", 8'(out_item_o.rx_nonempty), 8'(want.rx_nonempty));
      end
      results_checked++;
    end
  end

  initial begin
    #200000;
    $display("timeout with %0d results outstanding", ring_outcomes.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    for (int c = 0; c < 2; c++) begin
      rx_wr[c] = 8'd0;
      rx_rd[c] = 8'd0;
      tx_wr[c] = 8'd0;
      tx_rd[c] = 8'd0;
      for (int a = 0; a < 256; a++) begin
        rx_mem[c][a] = 8'd0;
        tx_mem[c][a] = 8'd0;
      end
    end
    for (int s = 0; s < 5; s++) status_seen[s] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_items();
    wait_all_results();
    test_rx_ring_full();
    wait_all_results();
    test_tx_ring_full();
    wait_all_results();
    test_random_traffic();
    test_backpressure();

    wait_all_results();
    repeat (8) @(posedge clk_i);
    $display("%0d items sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatches);
    $display("ok %0d, rx drops %0d, empty reads %0d, tx rejects %0d, idle sends %0d",
             status_seen[ST_OK], status_seen[ST_RX_FULL], status_seen[ST_RD_EMPTY],
             status_seen[ST_TX_FULL], status_seen[ST_NO_SEND]);
    if (mismatches == 0 && ring_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
